/* src/circular_array_queue_assert.svh */
// Assertion macros for the circular array queue, clocked on clk and gated by rst.
`ifndef CIRCULAR_ARRAY_QUEUE_ASSERT_SVH
`define CIRCULAR_ARRAY_QUEUE_ASSERT_SVH

// Checks a property at every rising edge of clk outside of reset.
`define CAQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checks that a condition in one cycle implies a consequence in the next.
`define CAQ_ASSERT_NEXT(lbl, cond, conseq, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) else $error(msg);

`endif

/* src/caq_pkg.sv */
// Shared types and constants of the circular array queue.
package caq_pkg;

  localparam int DEPTH_DEF      = 32;
  localparam int DATA_WIDTH_DEF = 32;

  localparam int KIND_W   = 2;
  localparam int VALUE_W  = 32;
  localparam int INDEX_W  = 5;
  localparam int CAP_W    = 6;
  localparam int COUNT_W  = 6;
  localparam int STATUS_W = 2;

  localparam logic [CAP_W-1:0] CAP_RESET = 6'd32;

  typedef enum logic [KIND_W-1:0] {
    KIND_PUSH  = 2'd0,
    KIND_POP   = 2'd1,
    KIND_READ  = 2'd2,
    KIND_WRITE = 2'd3
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  typedef struct packed {
    logic               rd;
    status_t            status;
    logic [COUNT_W-1:0] count;
  } resp_t;

endpackage

/* src/caq_in_if.sv */
// Operation channel of the circular array queue.
interface caq_in_if;
  logic                              valid;
  logic                              ready;
  logic [caq_pkg::KIND_W-1:0]        kind;
  logic signed [caq_pkg::VALUE_W-1:0] value;
  logic [caq_pkg::INDEX_W-1:0]       index;

  modport source (output valid, kind, value, index, input ready);
  modport sink (input valid, kind, value, index, output ready);
endinterface

/* src/caq_out_if.sv */
// Result channel of the circular array queue.
interface caq_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [caq_pkg::VALUE_W-1:0] data;
  logic [caq_pkg::STATUS_W-1:0]       status;
  logic [caq_pkg::COUNT_W-1:0]        count;

  modport source (output valid, data, status, count, input ready);
  modport sink (input valid, data, status, count, output ready);
endinterface

/* src/caq_ram.sv */
// Single-port slot memory with a registered read.
module caq_ram #(
  parameter int DEPTH      = caq_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = caq_pkg::DATA_WIDTH_DEF,
  parameter int PW         = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                  clk,
  input  logic                  we,
  input  logic                  re,
  input  logic [PW-1:0]         addr,
  input  logic [DATA_WIDTH-1:0] wdata,
  output logic [DATA_WIDTH-1:0] rdata
);

  logic [DATA_WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

/* src/caq_ctrl.sv */
// Head and count tracking, address generation and the result register.
`include "circular_array_queue_assert.svh"

module caq_ctrl #(
  parameter int DEPTH = caq_pkg::DEPTH_DEF,
  parameter int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [caq_pkg::CAP_W-1:0]     cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [caq_pkg::KIND_W-1:0]    in_kind,
  input  logic [caq_pkg::INDEX_W-1:0]   in_index,
  output logic                          mem_we,
  output logic                          mem_re,
  output logic [PW-1:0]                 mem_addr,
  output logic                          out_valid,
  input  logic                          out_ready,
  output caq_pkg::resp_t                resp
);

  localparam int CAP_LIMIT = (DEPTH < 63) ? DEPTH : 63;
  localparam logic [caq_pkg::CAP_W-1:0] CAP_MAX = caq_pkg::CAP_W'(CAP_LIMIT);

  logic [caq_pkg::CAP_W-1:0]   capacity;
  logic [caq_pkg::CAP_W-1:0]   head;
  logic [caq_pkg::COUNT_W-1:0] cnt;
  logic [caq_pkg::CAP_W-1:0]   head_next;
  logic [caq_pkg::COUNT_W-1:0] cnt_next;
  logic [caq_pkg::CAP_W-1:0]   cap_eff;
  logic [caq_pkg::CAP_W-1:0]   head_c;
  logic [caq_pkg::COUNT_W-1:0] cnt_c;
  logic [caq_pkg::CAP_W-1:0]   head_dec;
  logic [caq_pkg::CAP_W:0]     psum;
  logic [caq_pkg::CAP_W:0]     pdiff;
  logic [caq_pkg::CAP_W-1:0]   pos;
  logic                        accept;
  logic                        idx_bad;
  caq_pkg::status_t            status;
  logic                        rd;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    if (capacity == '0) begin
      cap_eff = caq_pkg::CAP_W'(1);
    end else if (capacity > CAP_MAX) begin
      cap_eff = CAP_MAX;
    end else begin
      cap_eff = capacity;
    end
    head_c   = (head >= cap_eff) ? '0 : head;
    cnt_c    = (cnt > cap_eff) ? cap_eff : cnt;
    head_dec = (head_c == '0) ? cap_eff - caq_pkg::CAP_W'(1) : head_c - caq_pkg::CAP_W'(1);
    psum     = {1'b0, head_c} + (caq_pkg::CAP_W + 1)'(in_index);
    pdiff    = psum - {1'b0, cap_eff};
    pos      = (psum >= {1'b0, cap_eff}) ? pdiff[caq_pkg::CAP_W-1:0]
                                         : psum[caq_pkg::CAP_W-1:0];
    if (int'(pos) >= DEPTH) begin
      pos = '0;
    end
    idx_bad = caq_pkg::COUNT_W'(in_index) >= cnt_c;
  end

  always_comb begin
    head_next = head_c;
    cnt_next  = cnt_c;
    status    = caq_pkg::ST_OK;
    rd        = 1'b0;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_addr  = PW'(pos);
    case (caq_pkg::kind_t'(in_kind))
      caq_pkg::KIND_PUSH: begin
        if (cnt_c >= cap_eff) begin
          status = caq_pkg::ST_FULL;
        end else begin
          head_next = head_dec;
          cnt_next  = cnt_c + caq_pkg::COUNT_W'(1);
          mem_we    = accept;
          mem_addr  = PW'(head_dec);
        end
      end
      caq_pkg::KIND_POP: begin
        if (cnt_c == '0) begin
          status = caq_pkg::ST_EMPTY;
        end else begin
          cnt_next = cnt_c - caq_pkg::COUNT_W'(1);
        end
      end
      caq_pkg::KIND_READ: begin
        if (idx_bad) begin
          status = caq_pkg::ST_RANGE;
        end else begin
          rd     = 1'b1;
          mem_re = accept;
        end
      end
      caq_pkg::KIND_WRITE: begin
        if (idx_bad) begin
          status = caq_pkg::ST_RANGE;
        end else begin
          mem_we = accept;
        end
      end
      default: begin
        status = caq_pkg::ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= caq_pkg::CAP_RESET;
      head     <= '0;
      cnt      <= '0;
    end else if (cfg_we) begin
      capacity <= cfg_data;
      head     <= '0;
      cnt      <= '0;
    end else if (accept) begin
      head <= head_next;
      cnt  <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      resp.rd     <= rd;
      resp.status <= status;
      resp.count  <= cnt_next;
    end
  end

  `CAQ_ASSERT(a_cnt_in_cap, cnt <= cap_eff, "Element count exceeds the capacity in use.")
  `CAQ_ASSERT(a_head_in_cap, head < cap_eff, "Head lies outside the ring in use.")
  `CAQ_ASSERT(a_mem_one_op, !(mem_we && mem_re), "Memory read and write in the same cycle.")
  `CAQ_ASSERT_NEXT(a_push_grows, accept && !cfg_we && in_kind == caq_pkg::KIND_PUSH && cnt_c < cap_eff, cnt == $past(cnt_c) + caq_pkg::COUNT_W'(1), "Accepted push did not grow the count.")
  `CAQ_ASSERT_NEXT(a_read_result, accept && mem_re, out_valid && resp.rd, "Memory read without a pending read result.")

endmodule

/* src/circular_array_queue.sv */
// Top level of the circular array queue: ring of slots with push, pop and indexed access.
//
//   channel  direction  carries
//   in_ch    sink       kind, value, index
//   out_ch   source     data, status, count
//   cfg      write      cfg_we, cfg_data (capacity)
//
// One transaction is accepted per cycle while no result is stalled; its result is shown in the next cycle.
// The single memory port is used at most once per transaction, and the memory's read register
// holds the read data, so a stalled result blocks new input until it is taken.
// Reset sets the capacity to 32 and empties the queue; slot contents are not cleared.
// A capacity write empties the queue and leaves the slots as they are.
module circular_array_queue #(
  parameter int DEPTH      = caq_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = caq_pkg::DATA_WIDTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [caq_pkg::CAP_W-1:0] cfg_data,
  caq_in_if.sink                    in_ch,
  caq_out_if.source                 out_ch
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic                  mem_we;
  logic                  mem_re;
  logic [PW-1:0]         mem_addr;
  logic [DATA_WIDTH-1:0] wdata;
  logic [DATA_WIDTH-1:0] rdata;
  caq_pkg::resp_t        resp;

  assign wdata = DATA_WIDTH'($unsigned(in_ch.value));

  caq_ctrl #(
    .DEPTH (DEPTH),
    .PW    (PW)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_kind   (in_ch.kind),
    .in_index  (in_ch.index),
    .mem_we    (mem_we),
    .mem_re    (mem_re),
    .mem_addr  (mem_addr),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .resp      (resp)
  );

  caq_ram #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH),
    .PW         (PW)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .re    (mem_re),
    .addr  (mem_addr),
    .wdata (wdata),
    .rdata (rdata)
  );

  assign out_ch.data   = resp.rd ? caq_pkg::VALUE_W'(rdata) : '0;
  assign out_ch.status = resp.status;
  assign out_ch.count  = resp.count;

endmodule
